// ===== rtl/core/cordic_cos_pkg.sv =====
// Shared types and constants for the CORDIC cosine pipeline.
package cordic_cos_pkg;

  localparam int unsigned ValW     = 20;
  localparam int unsigned AngleW   = 16;
  localparam int unsigned CosW     = 16;
  localparam int unsigned MaxSteps = 16;

  typedef logic signed [ValW-1:0]   val_t;
  typedef logic signed [AngleW-1:0] angle_t;
  typedef logic signed [CosW-1:0]   cos_t;

  localparam val_t GainStart = val_t'(39797);
  localparam val_t QuarterPi = val_t'(51472);
  localparam val_t OutMax    = val_t'(16384);
  localparam val_t RoundHalf = val_t'(2);

  localparam val_t AtanTab [MaxSteps] = '{
    val_t'(51472), val_t'(30386), val_t'(16055), val_t'(8150),
    val_t'(4091),  val_t'(2047),  val_t'(1024),  val_t'(512),
    val_t'(256),   val_t'(128),   val_t'(64),    val_t'(32),
    val_t'(16),    val_t'(8),     val_t'(4),     val_t'(2)
  };

endpackage

// ===== rtl/core/cordic_cosine_top.sv =====
// Pipelined CORDIC cosine: one rotation per register stage, saturated Q1.14 result.
// Each transaction passes the load stage, the rotation stages and the output register.
// Throughput: one transaction per cycle; one pipeline stage per CORDIC rotation.
// A stalled output holds the whole pipeline in place; nothing is dropped.
// Reset (rst_n low, synchronous) clears all valid bits and mode_r to 0.
module cordic_cosine_top #(
  parameter int unsigned ITERATIONS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cordic_cos_pkg::angle_t in_angle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cordic_cos_pkg::cos_t   out_cosine,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data
);
  import cordic_cos_pkg::*;

  localparam int unsigned Steps = (ITERATIONS < MaxSteps) ? ITERATIONS : MaxSteps;

  logic mode_r;
  logic en;
  logic vld_r [Steps+1];
  val_t tgt_r [Steps+1];
  val_t x_r   [Steps+1];
  val_t y_r   [Steps+1];
  val_t z_r   [Steps+1];
  logic out_vld_r;
  cos_t cos_r;
  cos_t cos_nxt;
  val_t xr;
  val_t rs;

  assign en        = !out_vld_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_cosine = cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  // load stage: Q3.13 angle to 16 fractional bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tgt_r[0] <= val_t'(in_angle) <<< 3;
      x_r[0]   <= GainStart;
      y_r[0]   <= '0;
      z_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_stage
    localparam val_t QpStep = QuarterPi >>> i;
    logic up;
    val_t step;
    val_t xs;
    val_t ys;
    val_t x_nxt;
    val_t y_nxt;
    val_t z_nxt;

    always_comb begin
      up   = z_r[i] > tgt_r[i];
      xs   = x_r[i] >>> i;
      ys   = y_r[i] >>> i;
      step = mode_r ? QpStep : AtanTab[i];
      if (up) begin
        x_nxt = x_r[i] - ys;
        y_nxt = y_r[i] + xs;
        z_nxt = z_r[i] - step;
      end else begin
        x_nxt = x_r[i] + ys;
        y_nxt = y_r[i] - xs;
        z_nxt = z_r[i] + step;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tgt_r[i+1] <= tgt_r[i];
        x_r[i+1]   <= x_nxt;
        y_r[i+1]   <= y_nxt;
        z_r[i+1]   <= z_nxt;
      end
    end
  end

  // round half up to Q1.14 and saturate to plus or minus one
  always_comb begin
    xr = x_r[Steps] + RoundHalf;
    rs = xr >>> 2;
    if (rs > OutMax) begin
      cos_nxt = cos_t'(OutMax);
    end else if (rs < -OutMax) begin
      cos_nxt = cos_t'(-OutMax);
    end else begin
      cos_nxt = rs[CosW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
    end
  end

endmodule
